@@ hw/rtl/mmlp_pkg.sv @@
`default_nettype none
package mmlp_pkg;

    // characters that steer the line phases
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_S       = 8'h73;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // operations handed from the front to the back
    typedef logic [2:0] op_t;
    localparam op_t OP_START  = 3'd0;
    localparam op_t OP_END    = 3'd1;
    localparam op_t OP_PERM   = 3'd2;
    localparam op_t OP_OFFSET = 3'd3;
    localparam op_t OP_DEV    = 3'd4;
    localparam op_t OP_INODE  = 3'd5;
    localparam op_t OP_PATH   = 3'd6;
    localparam op_t OP_RECORD = 3'd7;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } mmlp_entry_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

endpackage
`default_nettype wire

@@ hw/rtl/mmlp_in_if.sv @@
`default_nettype none
interface mmlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;

    modport source (output valid, output text_char, input ready);
    modport sink (input valid, input text_char, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mmlp_out_if.sv @@
`default_nettype none
interface mmlp_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  path_char;
    logic [63:0] start_address;
    logic [63:0] end_address;
    logic [3:0]  permissions;
    logic [63:0] file_offset;
    logic [31:0] device_number;
    logic [63:0] inode_number;
    logic [11:0] path_length;

    modport source (
        output valid, output item_kind, output path_char, output start_address,
        output end_address, output permissions, output file_offset,
        output device_number, output inode_number, output path_length,
        input ready
    );
    modport sink (
        input valid, input item_kind, input path_char, input start_address,
        input end_address, input permissions, input file_offset,
        input device_number, input inode_number, input path_length,
        output ready
    );
endinterface
`default_nettype wire

@@ hw/rtl/mmlp_front.sv @@
`default_nettype none
module mmlp_front import mmlp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    mmlp_in_if.sink     char_in,
    input  logic        queue_full,
    output logic        push,
    output mmlp_entry_t push_entry
);

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_END    = 3'd1;
    localparam logic [2:0] PH_FLAGS  = 3'd2;
    localparam logic [2:0] PH_OFFSET = 3'd3;
    localparam logic [2:0] PH_DEV    = 3'd4;
    localparam logic [2:0] PH_INODE  = 3'd5;
    localparam logic [2:0] PH_SKIP   = 3'd6;
    localparam logic [2:0] PH_PATH   = 3'd7;

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic       accept;
    logic       has_op;
    op_t        op;
    logic [7:0] ch;

    assign ch            = char_in.text_char;
    assign char_in.ready = !queue_full;
    assign accept        = char_in.valid && char_in.ready;

    // delimiters send nothing to the back; colons keep the phase
    always_comb
    begin
        phase_next = phase_reg;
        has_op     = 1'b1;
        op         = OP_PATH;
        case (phase_reg)
            PH_START:
            begin
                if (ch == CHAR_DASH)
                begin
                    phase_next = PH_END;
                    has_op     = 1'b0;
                end
                else
                begin
                    op = OP_START;
                end
            end
            PH_END:
            begin
                if (ch == CHAR_SPACE)
                begin
                    phase_next = PH_FLAGS;
                    has_op     = 1'b0;
                end
                else
                begin
                    op = OP_END;
                end
            end
            PH_FLAGS:
            begin
                if (ch == CHAR_SPACE)
                begin
                    phase_next = PH_OFFSET;
                    has_op     = 1'b0;
                end
                else
                begin
                    op = OP_PERM;
                end
            end
            PH_OFFSET:
            begin
                if (ch == CHAR_SPACE)
                begin
                    phase_next = PH_DEV;
                    has_op     = 1'b0;
                end
                else
                begin
                    op = OP_OFFSET;
                end
            end
            PH_DEV:
            begin
                if (ch == CHAR_SPACE)
                begin
                    phase_next = PH_INODE;
                    has_op     = 1'b0;
                end
                else if (ch == CHAR_COLON)
                begin
                    has_op = 1'b0;
                end
                else
                begin
                    op = OP_DEV;
                end
            end
            PH_INODE:
            begin
                if (ch == CHAR_SPACE)
                begin
                    phase_next = PH_SKIP;
                    has_op     = 1'b0;
                end
                else
                begin
                    op = OP_INODE;
                end
            end
            PH_SKIP:
            begin
                if (ch == CHAR_SPACE)
                begin
                    has_op = 1'b0;
                end
                else if (ch == CHAR_NEWLINE)
                begin
                    op         = OP_RECORD;
                    phase_next = PH_START;
                end
                else
                begin
                    op         = OP_PATH;
                    phase_next = PH_PATH;
                end
            end
            default:
            begin
                if (ch == CHAR_NEWLINE)
                begin
                    op         = OP_RECORD;
                    phase_next = PH_START;
                end
                else
                begin
                    op         = OP_PATH;
                    phase_next = PH_PATH;
                end
            end
        endcase
    end

    assign push            = accept && has_op;
    assign push_entry.op   = op;
    assign push_entry.data = ch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/mmlp_queue.sv @@
`default_nettype none
module mmlp_queue import mmlp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  mmlp_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output mmlp_entry_t pop_entry,
    output logic        empty
);

    mmlp_entry_t          entries_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    assign full      = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QPTR_BITS'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= QPTR_BITS'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count past depth");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/mmlp_back.sv @@
`default_nettype none
module mmlp_back import mmlp_pkg::*; #(
    parameter int ADDR_WIDTH    = 64,
    parameter int DEVICE_WIDTH  = 32,
    parameter int PATH_LEN_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  mmlp_entry_t pop_entry,
    input  logic        empty,
    output logic        pop,
    mmlp_out_if.source  result_out
);

    localparam logic [7:0]               CHAR_NINE     = 8'h39;
    localparam logic [7:0]               HEX_ALPHA_ADJ = 8'd9;
    localparam logic [PATH_LEN_BITS-1:0] PATH_MAX      = '1;

    logic [ADDR_WIDTH-1:0]    start_reg;
    logic [ADDR_WIDTH-1:0]    end_reg;
    logic [3:0]               perm_reg;
    logic [ADDR_WIDTH-1:0]    offset_reg;
    logic [DEVICE_WIDTH-1:0]  device_reg;
    logic [63:0]              inode_reg;
    logic [PATH_LEN_BITS-1:0] path_count_reg;

    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  path_char_reg;
    logic [63:0] start_out_reg;
    logic [63:0] end_out_reg;
    logic [3:0]  perm_out_reg;
    logic [63:0] offset_out_reg;
    logic [31:0] device_out_reg;
    logic [63:0] inode_out_reg;
    logic [11:0] length_out_reg;

    logic        slot_free;
    logic        is_out_op;
    logic [3:0]  nib;
    logic        flag;
    logic [63:0] inode_next;
    logic [63:0] device_ext;
    logic [15:0] length_ext;

    // letters a-f and A-F fold onto 10..15; other bytes above the digits take the same add
    assign nib  = (pop_entry.data <= CHAR_NINE) ? pop_entry.data[3:0]
                                                : 4'(pop_entry.data + HEX_ALPHA_ADJ);
    assign flag = (pop_entry.data != CHAR_DASH) && (pop_entry.data != CHAR_S);

    // times ten as two shifts and an add
    assign inode_next = {inode_reg[60:0], 3'b000} + {inode_reg[62:0], 1'b0}
                      + {60'd0, pop_entry.data[3:0]};

    assign device_ext = 64'(device_reg);
    assign length_ext = 16'(path_count_reg);

    assign slot_free = !out_valid_reg || result_out.ready;
    assign is_out_op = (pop_entry.op == OP_PATH) || (pop_entry.op == OP_RECORD);
    assign pop       = !empty && (!is_out_op || slot_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= '0;
            end_reg        <= '0;
            perm_reg       <= '0;
            offset_reg     <= '0;
            device_reg     <= '0;
            inode_reg      <= '0;
            path_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                case (pop_entry.op)
                    OP_START:
                    begin
                        start_reg <= {start_reg[ADDR_WIDTH-5:0], nib};
                    end
                    OP_END:
                    begin
                        end_reg <= {end_reg[ADDR_WIDTH-5:0], nib};
                    end
                    OP_PERM:
                    begin
                        perm_reg <= {perm_reg[2:0], flag};
                    end
                    OP_OFFSET:
                    begin
                        offset_reg <= {offset_reg[ADDR_WIDTH-5:0], nib};
                    end
                    OP_DEV:
                    begin
                        device_reg <= {device_reg[DEVICE_WIDTH-5:0], nib};
                    end
                    OP_INODE:
                    begin
                        inode_reg <= inode_next;
                    end
                    OP_PATH:
                    begin
                        out_valid_reg <= 1'b1;
                        if (path_count_reg != PATH_MAX)
                        begin
                            path_count_reg <= path_count_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        out_valid_reg  <= 1'b1;
                        start_reg      <= '0;
                        end_reg        <= '0;
                        perm_reg       <= '0;
                        offset_reg     <= '0;
                        device_reg     <= '0;
                        inode_reg      <= '0;
                        path_count_reg <= '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && is_out_op)
        begin
            if (pop_entry.op == OP_RECORD)
            begin
                kind_reg       <= 1'b1;
                path_char_reg  <= '0;
                start_out_reg  <= 64'(start_reg);
                end_out_reg    <= 64'(end_reg);
                perm_out_reg   <= perm_reg;
                offset_out_reg <= 64'(offset_reg);
                device_out_reg <= device_ext[31:0];
                inode_out_reg  <= inode_reg;
                length_out_reg <= length_ext[11:0];
            end
            else
            begin
                kind_reg       <= 1'b0;
                path_char_reg  <= pop_entry.data;
                start_out_reg  <= '0;
                end_out_reg    <= '0;
                perm_out_reg   <= '0;
                offset_out_reg <= '0;
                device_out_reg <= '0;
                inode_out_reg  <= '0;
                length_out_reg <= '0;
            end
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.item_kind     = kind_reg;
    assign result_out.path_char     = path_char_reg;
    assign result_out.start_address = start_out_reg;
    assign result_out.end_address   = end_out_reg;
    assign result_out.permissions   = perm_out_reg;
    assign result_out.file_offset   = offset_out_reg;
    assign result_out.device_number = device_out_reg;
    assign result_out.inode_number  = inode_out_reg;
    assign result_out.path_length   = length_out_reg;

`ifndef ASSERT_OFF
    a_record_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_entry.op == OP_RECORD) |=>
        (start_reg == '0 && inode_reg == '0 && path_count_reg == '0))
        else $error("accumulators not cleared after record");
    a_path_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_entry.op == OP_PATH && path_count_reg != PATH_MAX) |=>
        (path_count_reg == $past(path_count_reg) + 1'b1))
        else $error("path count did not advance");
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && is_out_op) |-> slot_free)
        else $error("result register overwritten while held");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/memory_map_line_parser_core.sv @@
`default_nettype none
// Memory-map listing parser. Takes one text character per beat on char_in and
// returns, on result_out, one beat for every path character (item_kind 0)
// and one completed record at each newline after the inode field
// (item_kind 1). Sustained rate is one character per cycle while the queue
// has room: the front keeps the line phase and classifies each character in
// the cycle it is accepted, and the back updates one accumulator per cycle
// (nibble shift, flag shift or times-ten add). Field delimiters send nothing
// to the back. A character's result beat comes from its queue entry through
// the result register; a four-entry queue between the two halves and the
// result register let input keep flowing while a result waits to be taken.
module memory_map_line_parser_core import mmlp_pkg::*; #(
    parameter int ADDR_WIDTH    = 64,
    parameter int DEVICE_WIDTH  = 32,
    parameter int PATH_LEN_BITS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    mmlp_in_if.sink    char_in,
    mmlp_out_if.source result_out
);

    logic        push;
    mmlp_entry_t push_entry;
    logic        full;
    logic        pop;
    mmlp_entry_t pop_entry;
    logic        empty;

    mmlp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    mmlp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    mmlp_back #(
        .ADDR_WIDTH    (ADDR_WIDTH),
        .DEVICE_WIDTH  (DEVICE_WIDTH),
        .PATH_LEN_BITS (PATH_LEN_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_entry  (pop_entry),
        .empty      (empty),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule
`default_nettype wire

@@ dv/tb_memory_map_line_parser_core.sv @@
`default_nettype none
module tb_memory_map_line_parser_core;
    import mmlp_pkg::*;

    localparam logic KIND_PATH   = 1'b0;
    localparam logic KIND_RECORD = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   HOLD_CYCLES = 300;

    typedef enum logic [2:0] {
        PH_START_ADDR,
        PH_END_ADDR,
        PH_FLAGS,
        PH_OFFSET,
        PH_DEVICE,
        PH_INODE,
        PH_SPACES,
        PH_PATH
    } line_phase_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  path_char;
        logic [63:0] start_address;
        logic [63:0] end_address;
        logic [3:0]  permissions;
        logic [63:0] file_offset;
        logic [31:0] device_number;
        logic [63:0] inode_number;
        logic [11:0] path_length;
    } map_item_t;

    logic clk = 1'b0;
    logic rst_n;

    mmlp_in_if  char_if ();
    mmlp_out_if result_if ();

    memory_map_line_parser_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_if),
        .result_out (result_if)
    );

    always #10 clk = ~clk;

    // parse state of the line being predicted
    line_phase_t line_phase = PH_START_ADDR;
    logic [63:0] start_acc  = '0;
    logic [63:0] end_acc    = '0;
    logic [3:0]  perm_acc   = '0;
    logic [63:0] offset_acc = '0;
    logic [31:0] device_acc = '0;
    logic [63:0] inode_acc  = '0;
    logic [11:0] path_count = '0;

    logic [7:0] text_queue[$];
    map_item_t  predicted_items[$];
    int         queued_total   = 0;
    int         error_count    = 0;
    int         cycle_count    = 0;
    int         send_idle_pct  = 11;
    int         recv_idle_pct  = 11;
    int         recv_hold_left = 0;
    string      hex_chars      = "0123456789abcdefABCDEF";
    map_item_t  seen_item;
    map_item_t  due_item;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] shifted;
        shifted = c + 8'd9;
        if (c <= 8'h39)
        begin
            return c[3:0];
        end
        return shifted[3:0];
    endfunction

    function automatic void parse_map_char(input logic [7:0] c);
        map_item_t item;
        item = '0;
        case (line_phase)
            PH_START_ADDR:
                if (c == CHAR_DASH)
                    line_phase = PH_END_ADDR;
                else
                    start_acc = {start_acc[59:0], hex_value(c)};
            PH_END_ADDR:
                if (c == CHAR_SPACE)
                    line_phase = PH_FLAGS;
                else
                    end_acc = {end_acc[59:0], hex_value(c)};
            PH_FLAGS:
                if (c == CHAR_SPACE)
                    line_phase = PH_OFFSET;
                else
                    perm_acc = {perm_acc[2:0], (c != CHAR_DASH && c != CHAR_S)};
            PH_OFFSET:
                if (c == CHAR_SPACE)
                    line_phase = PH_DEVICE;
                else
                    offset_acc = {offset_acc[59:0], hex_value(c)};
            PH_DEVICE:
                if (c == CHAR_SPACE)
                    line_phase = PH_INODE;
                else if (c != CHAR_COLON)
                    device_acc = {device_acc[27:0], hex_value(c)};
            PH_INODE:
                if (c == CHAR_SPACE)
                    line_phase = PH_SPACES;
                else
                    inode_acc = inode_acc * 64'd10 + {60'd0, c[3:0]};
            default:
                if (c == CHAR_NEWLINE)
                begin
                    item.item_kind     = KIND_RECORD;
                    item.start_address = start_acc;
                    item.end_address   = end_acc;
                    item.permissions   = perm_acc;
                    item.file_offset   = offset_acc;
                    item.device_number = device_acc;
                    item.inode_number  = inode_acc;
                    item.path_length   = path_count;
                    predicted_items.push_back(item);
                    line_phase = PH_START_ADDR;
                    start_acc  = '0;
                    end_acc    = '0;
                    perm_acc   = '0;
                    offset_acc = '0;
                    device_acc = '0;
                    inode_acc  = '0;
                    path_count = '0;
                end
                else if (!(c == CHAR_SPACE && line_phase == PH_SPACES))
                begin
                    item.item_kind = KIND_PATH;
                    item.path_char = c;
                    predicted_items.push_back(item);
                    if (path_count != '1)
                        path_count = path_count + 12'd1;
                    line_phase = PH_PATH;
                end
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic push_char(input logic [7:0] c);
        text_queue.push_back(c);
        queued_total++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_char(s[i]);
        end
    endtask

    // any byte that closes no field
    function automatic logic [7:0] filler_byte();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(255));
        end
        while (c == CHAR_SPACE || c == CHAR_DASH || c == CHAR_NEWLINE);
        return c;
    endfunction

    function automatic logic [7:0] hex_char();
        return hex_chars[$urandom_range(21)];
    endfunction

    task automatic push_hex_field(input int digits);
        repeat (digits)
        begin
            if ($urandom_range(19) == 0)
                push_char(filler_byte());
            else
                push_char(hex_char());
        end
    endtask

    // long fields now and then so the accumulators wrap
    function automatic int addr_digits();
        if ($urandom_range(9) == 0)
            return $urandom_range(17, 20);
        return $urandom_range(1, 16);
    endfunction

    task automatic push_map_line();
        logic [7:0] c;
        push_hex_field(addr_digits());
        push_char(CHAR_DASH);
        push_hex_field(addr_digits());
        push_char(CHAR_SPACE);
        if ($urandom_range(4) != 0)
        begin
            push_char($urandom_range(1) ? "r" : CHAR_DASH);
            push_char($urandom_range(1) ? "w" : CHAR_DASH);
            push_char($urandom_range(1) ? "x" : CHAR_DASH);
            push_char($urandom_range(1) ? "p" : CHAR_S);
        end
        else
        begin
            repeat ($urandom_range(1, 6)) push_char(filler_byte());
        end
        push_char(CHAR_SPACE);
        push_hex_field(addr_digits());
        push_char(CHAR_SPACE);
        if ($urandom_range(6) != 0)
        begin
            push_hex_field($urandom_range(1, 3));
            push_char(CHAR_COLON);
            push_hex_field($urandom_range(1, 3));
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                push_char(($urandom_range(3) == 0) ? CHAR_COLON : hex_char());
        end
        push_char(CHAR_SPACE);
        repeat (($urandom_range(9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 8))
        begin
            if ($urandom_range(24) == 0)
                push_char(filler_byte());
            else
                push_char(8'($urandom_range(48, 57)));
        end
        push_char(CHAR_SPACE);
        repeat (($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3))
            push_char(CHAR_SPACE);
        repeat (($urandom_range(3) == 0) ? 0 : $urandom_range(1, 24))
        begin
            if ($urandom_range(9) < 7)
                c = 8'($urandom_range(32, 126));
            else
            begin
                do
                begin
                    c = 8'($urandom_range(255));
                end
                while (c == CHAR_NEWLINE);
            end
            push_char(c);
        end
        push_char(CHAR_NEWLINE);
    endtask

    task automatic push_random_text(input int count);
        int stop_at;
        int pick;
        stop_at = queued_total + count;
        while (queued_total < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
                push_map_line();
            else if (pick < 93)
            begin
                // delimiter-heavy noise
                repeat ($urandom_range(1, 30))
                begin
                    case ($urandom_range(9))
                        0: push_char(CHAR_SPACE);
                        1: push_char(CHAR_DASH);
                        2: push_char(CHAR_NEWLINE);
                        3: push_char(CHAR_COLON);
                        default: push_char(8'($urandom_range(255)));
                    endcase
                end
            end
            else
            begin
                // line cut short inside the end address
                push_hex_field(addr_digits());
                push_char(CHAR_DASH);
                push_hex_field($urandom_range(1, 8));
                push_char(CHAR_NEWLINE);
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (text_queue.size() != 0 || char_if.valid || predicted_items.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // driver: predicts each accepted beat, then offers the next character
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_if.valid && char_if.ready)
                parse_map_char(char_if.text_char);
            if (!char_if.valid || char_if.ready)
            begin
                if (text_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    char_if.valid     <= 1'b1;
                    char_if.text_char <= text_queue.pop_front();
                end
                else
                    char_if.valid <= 1'b0;
            end
        end
    end

    // monitor: checks result beats in order and throttles ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                seen_item = '{result_if.item_kind, result_if.path_char,
                              result_if.start_address, result_if.end_address,
                              result_if.permissions, result_if.file_offset,
                              result_if.device_number, result_if.inode_number,
                              result_if.path_length};
                if (predicted_items.size() == 0)
                    report_error($sformatf("unexpected result beat kind %0b",
                                           seen_item.item_kind));
                else
                begin
                    due_item = predicted_items.pop_front();
                    if (seen_item.item_kind !== due_item.item_kind)
                        report_error($sformatf("item_kind got %0b want %0b",
                                               seen_item.item_kind, due_item.item_kind));
                    if (seen_item.path_char !== due_item.path_char)
                        report_error($sformatf("path_char got %h want %h",
                                               seen_item.path_char, due_item.path_char));
                    if (seen_item.start_address !== due_item.start_address)
                        report_error($sformatf("start_address got %h want %h",
                                               seen_item.start_address, due_item.start_address));
                    if (seen_item.end_address !== due_item.end_address)
                        report_error($sformatf("end_address got %h want %h",
                                               seen_item.end_address, due_item.end_address));
                    if (seen_item.permissions !== due_item.permissions)
                        report_error($sformatf("permissions got %h want %h",
                                               seen_item.permissions, due_item.permissions));
                    if (seen_item.file_offset !== due_item.file_offset)
                        report_error($sformatf("file_offset got %h want %h",
                                               seen_item.file_offset, due_item.file_offset));
                    if (seen_item.device_number !== due_item.device_number)
                        report_error($sformatf("device_number got %h want %h",
                                               seen_item.device_number, due_item.device_number));
                    if (seen_item.inode_number !== due_item.inode_number)
                        report_error($sformatf("inode_number got %h want %h",
                                               seen_item.inode_number, due_item.inode_number));
                    if (seen_item.path_length !== due_item.path_length)
                        report_error($sformatf("path_length got %0d want %0d",
                                               seen_item.path_length, due_item.path_length));
                end
            end
            if (recv_hold_left > 0)
            begin
                recv_hold_left   <= recv_hold_left - 1;
                result_if.ready  <= 1'b0;
            end
            else
                result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", predicted_items.size());
            $display("memory_map_line_parser_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        char_if.valid     = 1'b0;
        char_if.text_char = 8'h00;
        result_if.ready   = 1'b0;
        rst_n             = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty start, high non-hex byte, s and dash flags, bare colon, empty path
        push_text("-");
        push_char(8'hFF);
        push_text(" s-r  : 9 \n");
        // newline inside end address, five flags, letter outside hex, path with high byte
        push_text("0-\nG wxyzq 0 A:f 99  /");
        push_char(8'h80);
        push_char(8'h00);
        push_char(CHAR_NEWLINE);
        wait_drained();

        // path long enough to saturate the length count
        push_text("1-2 r 3 4:5 6 ");
        repeat (4100) push_char(8'($urandom_range(33, 126)));
        push_char(CHAR_NEWLINE);
        wait_drained();

        // long receiver hold while the sender keeps offering
        push_random_text(600);
        recv_hold_left = HOLD_CYCLES;
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random_text(400);
        wait_drained();

        send_idle_pct = 11;
        recv_idle_pct = 11;
        push_random_text(650);
        wait_drained();
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("memory_map_line_parser_core regression: pass");
        else
            $display("memory_map_line_parser_core regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

@@ memory_map_line_parser_core.f @@
hw/rtl/mmlp_pkg.sv
hw/rtl/mmlp_in_if.sv
hw/rtl/mmlp_out_if.sv
hw/rtl/mmlp_front.sv
hw/rtl/mmlp_queue.sv
hw/rtl/mmlp_back.sv
hw/rtl/memory_map_line_parser_core.sv
dv/tb_memory_map_line_parser_core.sv
